@@ src/cfbs_pkg.sv @@
// shared types, constants and crc helper for the crc framed bit serializer
package cfbs_pkg;

  localparam int PAYLOAD_BYTES  = 16;
  localparam int PREAMBLE_BYTES = 4;

  localparam int DATA_BITS = PAYLOAD_BYTES * 8;
  localparam int PRE_BITS  = PREAMBLE_BYTES * 8;
  localparam int WORD_BITS = 16;
  localparam int MAX_BITS  = (DATA_BITS > PRE_BITS) ?
                             ((DATA_BITS > WORD_BITS) ? DATA_BITS : WORD_BITS) :
                             ((PRE_BITS > WORD_BITS) ? PRE_BITS : WORD_BITS);
  localparam int POS_W  = $clog2(MAX_BITS);
  localparam int ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CNT_W  = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [POS_W-1:0] PRE_LAST  = POS_W'(PRE_BITS - 1);
  localparam logic [POS_W-1:0] WORD_LAST = POS_W'(WORD_BITS - 1);
  localparam logic [POS_W-1:0] DATA_LAST = POS_W'(DATA_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(PAYLOAD_BYTES);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0]  RST_PREAMBLE = 8'hAA;
  localparam logic [15:0] RST_SYNC     = 16'h2DD4;
  localparam logic [15:0] RST_BIT_TIME = 16'd208;
  localparam logic [15:0] RST_GAP_TIME = 16'd20000;
  localparam logic [2:0]  RST_REPEATS  = 3'd3;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_PREAMBLE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SYNC     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_BIT_TIME = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GAP_TIME = 3'd3;
  localparam logic [CFG_AW-1:0] REG_REPEATS  = 3'd4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_SYNC     = 3'd1,
    PH_DATA     = 3'd2,
    PH_CRC      = 3'd3,
    PH_GAP      = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic        from_ram;
    logic [2:0]  bit_sel;
    logic        level;
    logic [15:0] dur;
    logic        fin;
  } sym_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic pick_bit(input logic [7:0] b, input logic [2:0] sel);
    return b[3'd7 - sel];
  endfunction

endpackage

@@ src/cfbs_ram.sv @@
// generic single write port, single read port ram with registered read
module cfbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/crc_framed_bit_serializer.sv @@
// top level of the crc framed bit serializer
//
// input channel: in_tuser is the opcode. opcode 0 loads in_tdata as the next
// payload byte and gives no result; opcode 1 requests the next symbol and
// gives exactly one result. a crc-16 ccitt runs over the payload as it loads;
// once the payload is full the frame is armed and symbols come out msb first:
// preamble bytes, sync word, payload, crc high and low byte, one low gap.
// the frame repeats as configured, then every request reports finished.
// loading a byte after a full payload drops the frame and starts a new one.
// payload bytes live in a small ram, read in the stage ahead of the output register.
// result channel: out_tdata carries level and duration, out_tuser finished.
// an accepted item passes the ram read stage and then the output register
// before out_tvalid. one item per cycle is taken when the result side keeps
// up. when the receiver stalls the output register and the read stage fill,
// then in_tready drops until out_tready returns.
// reset (rst_n low at a clock edge) restores the register defaults and
// leaves nothing armed; the payload ram is not cleared.
// configuration: cfg_we writes cfg_wdata to register cfg_addr.
module crc_framed_bit_serializer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // payload_byte
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // line_level, duration_us, zero pad
  output logic        out_tuser,  // finished
  input  logic        cfg_we,
  input  logic [cfbs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [cfbs_pkg::CFG_DW-1:0] cfg_wdata
);

  logic [7:0]  preamble_r;
  logic [15:0] sync_r;
  logic [15:0] bit_time_r;
  logic [15:0] gap_time_r;
  logic [2:0]  repeats_total_r;

  logic [15:0]                  crc_r, crc_nxt;
  logic [cfbs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  cfbs_pkg::phase_t             phase_r, phase_nxt;
  logic [cfbs_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [2:0]                   reps_r, reps_nxt;

  logic           s1_v_r, s1_v_nxt;
  cfbs_pkg::sym_t s1_r, s1_nxt;
  logic           out_v_r, out_v_nxt;
  logic           out_level_r, out_level_nxt;
  logic [15:0]    out_dur_r, out_dur_nxt;
  logic           out_fin_r, out_fin_nxt;

  logic s1_go, acc, req, load;
  logic [cfbs_pkg::CNT_W-1:0]  eff_cnt;
  logic [15:0]                 eff_crc;
  logic                        ram_we, ram_re;
  logic [cfbs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]                  ram_rdata;
  logic [7:0]                  word_byte;

  assign s1_go     = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_go;
  assign acc       = in_tvalid && in_tready;
  assign req       = acc && (in_tuser == cfbs_pkg::OP_REQUEST);
  assign load      = acc && (in_tuser == cfbs_pkg::OP_LOAD);

  assign eff_cnt   = (cnt_r == cfbs_pkg::CNT_FULL) ? '0 : cnt_r;
  assign eff_crc   = (cnt_r == cfbs_pkg::CNT_FULL) ? cfbs_pkg::CRC_INIT : crc_r;
  assign ram_we    = load;
  assign ram_waddr = eff_cnt[cfbs_pkg::ADDR_W-1:0];
  assign ram_re    = req && (phase_r == cfbs_pkg::PH_DATA);
  assign ram_raddr = pos_r[3 +: cfbs_pkg::ADDR_W];

  cfbs_ram #(
    .WIDTH (8),
    .DEPTH (cfbs_pkg::PAYLOAD_BYTES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r      <= cfbs_pkg::RST_PREAMBLE;
      sync_r          <= cfbs_pkg::RST_SYNC;
      bit_time_r      <= cfbs_pkg::RST_BIT_TIME;
      gap_time_r      <= cfbs_pkg::RST_GAP_TIME;
      repeats_total_r <= cfbs_pkg::RST_REPEATS;
    end else if (cfg_we) begin
      case (cfg_addr)
        cfbs_pkg::REG_PREAMBLE: preamble_r      <= cfg_wdata[7:0];
        cfbs_pkg::REG_SYNC:     sync_r          <= cfg_wdata;
        cfbs_pkg::REG_BIT_TIME: bit_time_r      <= cfg_wdata;
        cfbs_pkg::REG_GAP_TIME: gap_time_r      <= cfg_wdata;
        cfbs_pkg::REG_REPEATS:  repeats_total_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // sync and crc words, high byte first
  always_comb begin
    if (phase_r == cfbs_pkg::PH_SYNC) begin
      word_byte = pos_r[3] ? sync_r[7:0] : sync_r[15:8];
    end else begin
      word_byte = pos_r[3] ? crc_r[7:0] : crc_r[15:8];
    end
  end

  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    reps_nxt  = reps_r;
    s1_nxt    = s1_r;

    if (load) begin
      crc_nxt = cfbs_pkg::crc_byte(eff_crc, in_tdata);
      cnt_nxt = eff_cnt + 1'b1;
      if (cnt_nxt == cfbs_pkg::CNT_FULL) begin
        phase_nxt = cfbs_pkg::PH_PREAMBLE;
        pos_nxt   = '0;
        reps_nxt  = '0;
      end else begin
        phase_nxt = cfbs_pkg::PH_DONE;
      end
    end else if (req) begin
      s1_nxt.from_ram = 1'b0;
      s1_nxt.bit_sel  = pos_r[2:0];
      s1_nxt.level    = 1'b0;
      s1_nxt.dur      = bit_time_r;
      s1_nxt.fin      = 1'b0;
      pos_nxt         = pos_r + 1'b1;
      case (phase_r)
        cfbs_pkg::PH_PREAMBLE: begin
          s1_nxt.level = cfbs_pkg::pick_bit(preamble_r, pos_r[2:0]);
          if (pos_r == cfbs_pkg::PRE_LAST) begin
            pos_nxt   = '0;
            phase_nxt = cfbs_pkg::PH_SYNC;
          end
        end
        cfbs_pkg::PH_SYNC: begin
          s1_nxt.level = cfbs_pkg::pick_bit(word_byte, pos_r[2:0]);
          if (pos_r == cfbs_pkg::WORD_LAST) begin
            pos_nxt   = '0;
            phase_nxt = cfbs_pkg::PH_DATA;
          end
        end
        cfbs_pkg::PH_DATA: begin
          s1_nxt.from_ram = 1'b1;
          if (pos_r == cfbs_pkg::DATA_LAST) begin
            pos_nxt   = '0;
            phase_nxt = cfbs_pkg::PH_CRC;
          end
        end
        cfbs_pkg::PH_CRC: begin
          s1_nxt.level = cfbs_pkg::pick_bit(word_byte, pos_r[2:0]);
          if (pos_r == cfbs_pkg::WORD_LAST) begin
            pos_nxt   = '0;
            phase_nxt = cfbs_pkg::PH_GAP;
          end
        end
        cfbs_pkg::PH_GAP: begin
          s1_nxt.dur = gap_time_r;
          pos_nxt    = pos_r;
          reps_nxt   = reps_r + 1'b1;
          if (reps_nxt >= repeats_total_r || reps_nxt == 3'd0) begin
            phase_nxt = cfbs_pkg::PH_DONE;
          end else begin
            phase_nxt = cfbs_pkg::PH_PREAMBLE;
            pos_nxt   = '0;
          end
        end
        default: begin
          s1_nxt.dur = '0;
          s1_nxt.fin = 1'b1;
          pos_nxt    = pos_r;
        end
      endcase
    end
  end

  always_comb begin
    s1_v_nxt      = in_tready ? req : s1_v_r;
    out_v_nxt     = out_v_r;
    out_level_nxt = out_level_r;
    out_dur_nxt   = out_dur_r;
    out_fin_nxt   = out_fin_r;
    if (s1_go) begin
      out_v_nxt     = s1_v_r;
      out_level_nxt = s1_r.from_ram ? cfbs_pkg::pick_bit(ram_rdata, s1_r.bit_sel) : s1_r.level;
      out_dur_nxt   = s1_r.dur;
      out_fin_nxt   = s1_r.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= cfbs_pkg::CRC_INIT;
      cnt_r   <= '0;
      phase_r <= cfbs_pkg::PH_DONE;
      pos_r   <= '0;
      reps_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      reps_r  <= reps_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r        <= s1_nxt;
    out_level_r <= out_level_nxt;
    out_dur_r   <= out_dur_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_dur_r, out_level_r};
  assign out_tuser  = out_fin_r;

endmodule

@@ src/cfbs_checker.sv @@
// port level checks for the crc framed bit serializer
module cfbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // finished marker carries a low level and zero duration
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[16:0] == 17'd0)
    else $error("finished marker with nonzero level or duration");

  // nothing is offered right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // input only backs up when the result side is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // a stalled result keeps its contents
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind crc_framed_bit_serializer cfbs_checker u_cfbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ sim/tb.sv @@
// self-checking testbench for the crc framed bit serializer: directed table, then random frames
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        level;
    logic [15:0] dur;
    logic        fin;
  } line_sym_t;

  typedef struct packed {
    logic      op;
    logic [7:0] data;
    logic      typed;
    line_sym_t want;
  } step_row_t;

  localparam int FRAME_SYMS  = cfbs_pkg::PRE_BITS + 2 * cfbs_pkg::WORD_BITS +
                               cfbs_pkg::DATA_BITS + 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 4;

  localparam line_sym_t NO_SYM  = '{1'b0, 16'd0, 1'b0};
  localparam line_sym_t FIN_SYM = '{1'b0, 16'd0, 1'b1};
  localparam line_sym_t PRE_HI  = '{1'b1, cfbs_pkg::RST_BIT_TIME, 1'b0};
  localparam line_sym_t PRE_LO  = '{1'b0, cfbs_pkg::RST_BIT_TIME, 1'b0};

  localparam step_row_t DIRECTED [25] = '{
    '{cfbs_pkg::OP_REQUEST, 8'h00, 1'b1, FIN_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h00, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_REQUEST, 8'hFF, 1'b1, FIN_SYM},
    '{cfbs_pkg::OP_LOAD,    8'hFF, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h80, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h01, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h7F, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'hFE, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h00, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'hFF, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h55, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'hAA, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h0F, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'hF0, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h12, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h34, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'hC3, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h3C, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_REQUEST, 8'h00, 1'b1, PRE_HI},
    '{cfbs_pkg::OP_REQUEST, 8'hFF, 1'b1, PRE_LO},
    '{cfbs_pkg::OP_REQUEST, 8'h00, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_LOAD,    8'h5A, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_REQUEST, 8'h00, 1'b1, FIN_SYM},
    '{cfbs_pkg::OP_LOAD,    8'hFF, 1'b0, NO_SYM},
    '{cfbs_pkg::OP_REQUEST, 8'hFF, 1'b1, FIN_SYM}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = 8'h00;   // payload_byte
  logic              in_tuser = 1'b0;    // opcode
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;          // line_level, duration_us, zero pad
  logic              out_tuser;          // finished
  logic              cfg_we = 1'b0;
  logic [cfbs_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [cfbs_pkg::CFG_DW-1:0] cfg_wdata = '0;

  // predictor copy of registers and frame state
  logic [7:0]  pre_byte = cfbs_pkg::RST_PREAMBLE;
  logic [15:0] sync_w   = cfbs_pkg::RST_SYNC;
  logic [15:0] bit_us   = cfbs_pkg::RST_BIT_TIME;
  logic [15:0] gap_us   = cfbs_pkg::RST_GAP_TIME;
  logic [2:0]  rep_total = cfbs_pkg::RST_REPEATS;
  logic [7:0]  payload_img [cfbs_pkg::PAYLOAD_BYTES];
  logic [15:0] crc_acc = cfbs_pkg::CRC_INIT;
  int          loaded_cnt = 0;
  cfbs_pkg::phase_t phase = cfbs_pkg::PH_DONE;
  int          bitpos = 0;
  logic [2:0]  reps_done = 3'd0;

  line_sym_t   symbols_due [$];
  int gap_pct = 0, stall_pct = 0, calm_in = 0, calm_out = 0;
  int items_sent = 0, mismatches = 0, cycles = 0;

  crc_framed_bit_serializer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    return r;
  endfunction

  function automatic bit serialize_item(input logic op, input logic [7:0] b,
                                        output line_sym_t s);
    logic [7:0]       src;
    int               total;
    cfbs_pkg::phase_t nxt;
    bit               from_byte;
    s = '{1'b0, bit_us, 1'b0};
    src = 8'h00;
    total = 1;
    nxt = cfbs_pkg::PH_DONE;
    from_byte = 1'b1;
    if (op == cfbs_pkg::OP_LOAD) begin
      if (loaded_cnt >= cfbs_pkg::PAYLOAD_BYTES) begin
        loaded_cnt = 0;
        crc_acc = cfbs_pkg::CRC_INIT;
      end
      phase = cfbs_pkg::PH_DONE;
      payload_img[loaded_cnt] = b;
      crc_acc = crc_ccitt_step(crc_acc, b);
      loaded_cnt++;
      if (loaded_cnt >= cfbs_pkg::PAYLOAD_BYTES) begin
        phase = cfbs_pkg::PH_PREAMBLE;
        bitpos = 0;
        reps_done = 3'd0;
      end
      return 1'b0;
    end
    case (phase)
      cfbs_pkg::PH_PREAMBLE: begin
        src = pre_byte;
        total = cfbs_pkg::PRE_BITS;
        nxt = cfbs_pkg::PH_SYNC;
      end
      cfbs_pkg::PH_SYNC: begin
        src = (bitpos < 8) ? sync_w[15:8] : sync_w[7:0];
        total = cfbs_pkg::WORD_BITS;
        nxt = cfbs_pkg::PH_DATA;
      end
      cfbs_pkg::PH_DATA: begin
        src = payload_img[bitpos / 8];
        total = cfbs_pkg::DATA_BITS;
        nxt = cfbs_pkg::PH_CRC;
      end
      cfbs_pkg::PH_CRC: begin
        src = (bitpos < 8) ? crc_acc[15:8] : crc_acc[7:0];
        total = cfbs_pkg::WORD_BITS;
        nxt = cfbs_pkg::PH_GAP;
      end
      cfbs_pkg::PH_GAP: begin
        from_byte = 1'b0;
        s.dur = gap_us;
        reps_done = reps_done + 3'd1;
        if (reps_done >= rep_total || reps_done == 3'd0) begin
          phase = cfbs_pkg::PH_DONE;
        end else begin
          phase = cfbs_pkg::PH_PREAMBLE;
          bitpos = 0;
        end
      end
      default: begin
        s = FIN_SYM;
        return 1'b1;
      end
    endcase
    if (from_byte) begin
      s.level = src[7 - (bitpos % 8)];
      bitpos++;
      if (bitpos >= total) begin
        bitpos = 0;
        phase = nxt;
      end
    end
    return 1'b1;
  endfunction

  task automatic push_item(input logic op, input logic [7:0] b, input logic typed,
                           input line_sym_t want);
    line_sym_t got;
    if (calm_in > 0) calm_in--;
    else if ($urandom_range(0, 39) == 0) calm_in = $urandom_range(8, 30);
    while (calm_in == 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (serialize_item(op, b, got)) symbols_due.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [cfbs_pkg::CFG_AW-1:0] addr,
                           input logic [cfbs_pkg::CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    case (addr)
      cfbs_pkg::REG_PREAMBLE: pre_byte = data[7:0];
      cfbs_pkg::REG_SYNC:     sync_w = data;
      cfbs_pkg::REG_BIT_TIME: bit_us = data;
      cfbs_pkg::REG_GAP_TIME: gap_us = data;
      cfbs_pkg::REG_REPEATS:  rep_total = data[2:0];
      default: ;
    endcase
  endtask

  task automatic program_line(input logic [7:0] pre, input logic [15:0] sync,
                              input logic [15:0] bit_t, input logic [15:0] gap_t,
                              input logic [15:0] reps);
    cfg_write(cfbs_pkg::REG_PREAMBLE, {8'($urandom), pre});
    cfg_write(cfbs_pkg::REG_SYNC, sync);
    cfg_write(cfbs_pkg::REG_BIT_TIME, bit_t);
    cfg_write(cfbs_pkg::REG_GAP_TIME, gap_t);
    cfg_write(cfbs_pkg::REG_REPEATS, reps);
    // unmapped index must leave the registers alone
    cfg_write(cfbs_pkg::CFG_AW'($urandom_range(5, 7)), cfbs_pkg::CFG_DW'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (symbols_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // 0 noise, 1 partial load with requests, 2 frame cut short by a load, else full frame
  task automatic run_frame(input int kind);
    int n;
    if (kind == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) push_item(1'($urandom), 8'($urandom), 1'b0, NO_SYM);
    end else if (kind == 1) begin
      n = $urandom_range(1, cfbs_pkg::PAYLOAD_BYTES - 1);
      repeat (n) begin
        push_item(cfbs_pkg::OP_LOAD, 8'($urandom), 1'b0, NO_SYM);
        if ($urandom_range(0, 3) == 0) begin
          push_item(cfbs_pkg::OP_REQUEST, 8'($urandom), 1'b0, NO_SYM);
        end
      end
    end else begin
      n = (loaded_cnt >= cfbs_pkg::PAYLOAD_BYTES) ? cfbs_pkg::PAYLOAD_BYTES :
          cfbs_pkg::PAYLOAD_BYTES - loaded_cnt;
      repeat (n) push_item(cfbs_pkg::OP_LOAD, 8'($urandom), 1'b0, NO_SYM);
      n = FRAME_SYMS * ((rep_total == 3'd0) ? 1 : int'(rep_total));
      n = (kind == 2) ? $urandom_range(1, FRAME_SYMS - 1) : n + $urandom_range(0, 3);
      repeat (n) push_item(cfbs_pkg::OP_REQUEST, 8'($urandom), 1'b0, NO_SYM);
    end
  endtask

  always @(negedge clk) begin
    if (calm_out > 0) calm_out <= calm_out - 1;
    else if ($urandom_range(0, 39) == 0) calm_out <= $urandom_range(8, 30);
    out_tready <= (calm_out != 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    line_sym_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (symbols_due.size() == 0) begin
        $error("unexpected item: out_tdata %h out_tuser %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = symbols_due.pop_front();
        if (out_tdata[0] !== want.level) begin
          $error("line_level: expected %0d, got %0d", want.level, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[16:1] !== want.dur) begin
          $error("duration_us: expected %0d, got %0d", want.dur, out_tdata[16:1]);
          mismatches++;
        end
        if (out_tuser !== want.fin) begin
          $error("finished: expected %0d, got %0d", want.fin, out_tuser);
          mismatches++;
        end
        if (out_tdata[23:17] !== 7'd0) begin
          $error("pad: expected 0, got %0h", out_tdata[23:17]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int start;
    int budget;
    bit first;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cfg_write(3'd7, 16'hFFFF);
    cfg_we <= 1'b0;
    for (int i = 0; i < 25; i++) begin
      push_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].want);
    end
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: program_line(8'h00, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFF8);
        1: program_line(8'hFF, 16'h0000, 16'hFFFF, 16'd1, 16'd1);
        2: program_line(8'($urandom), 16'($urandom), 16'd0, 16'd0, 16'd2);
        default: program_line(8'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
                              16'($urandom_range(1, 65535)), 16'd7);
      endcase
      gap_pct = (ph == 1) ? 66 : (ph == 3) ? 38 : 0;
      stall_pct = (ph == 2) ? 66 : (ph == 3) ? 38 : 0;
      start = items_sent;
      first = (ph == 0 || ph == 2);
      budget = first ? 1 : 50;
      while (items_sent - start < budget) begin
        run_frame(first ? 3 : $urandom_range(0, 2));
        first = 1'b0;
      end
    end
    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
